@@ hw/rtl/tmps_pkg.sv @@
// shared types and constants for the thread mask packet splitter
`timescale 1ns / 1ps

package tmps_pkg;

   // fixed field widths
   localparam int MASK_W = 32;
   localparam int TAG_W = 32;
   localparam int LANE_W = 8;
   localparam int GRP_W = 2;
   localparam int MAX_GROUPS = 4;

   // one issued instruction
   typedef struct packed {
      logic [MASK_W-1:0] thread_mask;
      logic              start_of_packet;
      logic              end_of_packet;
      logic [TAG_W-1:0]  instr_tag;
   } req_type;

   // one emitted packet
   typedef struct packed {
      logic [LANE_W-1:0] lane_mask;
      logic [GRP_W-1:0]  group_index;
      logic              sop_out;
      logic              eop_out;
      logic [TAG_W-1:0]  tag_out;
      logic              last;
   } rsp_type;

   // controller to datapath commands
   typedef struct packed {
      logic load;
      logic emit;
   } ctl_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic last_group;
   } dp_sts_type;

endpackage

@@ hw/rtl/tmps_datapath.sv @@
// datapath: instruction holding registers, group walk and packet output register
`timescale 1ns / 1ps

module tmps_datapath #(
   parameter int THREADS = 32,
   parameter int LANES = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  tmps_pkg::ctl_cmd_type cmd,
   output tmps_pkg::dp_sts_type  sts,
   input  tmps_pkg::req_type     req_data,
   output tmps_pkg::rsp_type     rsp_data
);

   localparam bit PASS = (LANES >= THREADS);

   // threads belonging to group g, limited to the usable thread range
   function automatic logic [tmps_pkg::MASK_W-1:0] group_select(int g);
      logic [tmps_pkg::MASK_W-1:0] m;
      int lo;
      int n;
      m = '0;
      lo = g * LANES;
      n = (THREADS < tmps_pkg::MASK_W) ? THREADS : tmps_pkg::MASK_W;
      for (int t = 0; t < tmps_pkg::MASK_W; t++) begin
         if (t >= lo && t < lo + LANES && t < n) m[t] = 1'b1;
      end
      return m;
   endfunction

   logic [tmps_pkg::MASK_W-1:0]     mask_ff;
   logic                            sop_ff;
   logic                            eop_ff;
   logic [tmps_pkg::TAG_W-1:0]      tag_ff;
   logic [tmps_pkg::MAX_GROUPS-1:0] rem_ff, rem_in;
   logic                            first_ff, first_in;
   tmps_pkg::rsp_type               rsp_ff, rsp_in;

   logic [tmps_pkg::MAX_GROUPS-1:0] req_any;
   logic [tmps_pkg::LANE_W-1:0]     grp_bits [tmps_pkg::MAX_GROUPS];
   logic [tmps_pkg::GRP_W-1:0]      sel_idx;
   logic                            last_group;

   // per-group activity and lane bits
   for (genvar g = 0; g < tmps_pkg::MAX_GROUPS; g++) begin : g_group
      localparam logic [tmps_pkg::MASK_W-1:0] SEL = group_select(g);
      localparam int SHIFT = g * LANES;
      logic [tmps_pkg::MASK_W-1:0] shifted;
      assign req_any[g] = |(req_data.thread_mask & SEL);
      assign shifted = (mask_ff & SEL) >> SHIFT;
      assign grp_bits[g] = shifted[tmps_pkg::LANE_W-1:0];
   end

   // lowest group still pending
   always_comb begin
      sel_idx = '0;
      for (int g = tmps_pkg::MAX_GROUPS - 1; g >= 0; g--) begin
         if (rem_ff[g]) sel_idx = tmps_pkg::GRP_W'(g);
      end
   end

   assign last_group = ((rem_ff & (rem_ff - 1'b1)) == '0);
   assign sts.last_group = last_group;

   // next values of the walk and the output register
   always_comb begin
      rem_in = rem_ff;
      first_in = first_ff;
      rsp_in = rsp_ff;
      if (cmd.load) begin
         // pass-through or empty mask walks group 0 alone
         if (PASS || req_any == '0) rem_in = tmps_pkg::MAX_GROUPS'(1);
         else rem_in = req_any;
         first_in = 1'b1;
      end else if (cmd.emit) begin
         rem_in = rem_ff & (rem_ff - 1'b1);
         first_in = 1'b0;
         rsp_in.lane_mask = grp_bits[sel_idx];
         rsp_in.group_index = sel_idx;
         rsp_in.sop_out = sop_ff & first_ff;
         rsp_in.eop_out = eop_ff & last_group;
         rsp_in.tag_out = tag_ff;
         rsp_in.last = last_group;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff <= '0;
         first_ff <= 1'b0;
      end else begin
         rem_ff <= rem_in;
         first_ff <= first_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mask_ff <= req_data.thread_mask;
         sop_ff <= req_data.start_of_packet;
         eop_ff <= req_data.end_of_packet;
         tag_ff <= req_data.instr_tag;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_data = rsp_ff;

   // a loaded instruction always has a group to emit
   a_load_nonempty: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> rem_ff != '0)
      else $error("no pending group after load");

   // only the first packet may carry sop
   a_sop_first_only: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> !first_ff)
      else $error("first flag survived an emitted packet");

endmodule

@@ hw/rtl/tmps_controller.sv @@
// controller: instruction acceptance and packet issue sequencing
`timescale 1ns / 1ps

module tmps_controller (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output tmps_pkg::ctl_cmd_type cmd,
   input  tmps_pkg::dp_sts_type  sts
);

   typedef enum logic {
      IDLE,
      BUSY
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;

   // command decode
   assign req_ready = (state_ff == IDLE);
   assign cmd.load = req_valid && (state_ff == IDLE);
   assign cmd.emit = (state_ff == BUSY) && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid = rsp_valid_ff;

   // state and output valid
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         case (state_ff)
            IDLE: begin
               if (req_valid) state_ff <= BUSY;
            end
            BUSY: begin
               if (cmd.emit && sts.last_group) state_ff <= IDLE;
            end
            default: state_ff <= IDLE;
         endcase
         if (cmd.emit) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   // issuing the final packet ends the instruction
   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      cmd.emit && sts.last_group |=> state_ff == IDLE && rsp_valid_ff)
      else $error("controller did not finish after final packet");

   // a stalled packet is never overwritten
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready |-> !cmd.emit)
      else $error("packet issued over a stalled transaction");

endmodule

@@ hw/rtl/thread_mask_packet_splitter_unit.sv @@
// top level of the thread mask packet splitter
`timescale 1ns / 1ps
// Usage:
//   req channel: one issued instruction per transaction (thread mask, sop, eop, tag).
//   rsp channel: one packet per active group of LANES threads, lowest group first;
//   the final packet of an instruction has last set and carries eop, the first
//   carries sop. An empty mask, or LANES >= THREADS, gives a single packet for group 0.
//   Only groups 0..3 and threads 0..31 are looked at.
// Timing:
//   An instruction that yields P packets (1 to 4) is first taken into the holding
//   registers, then the group walk gives one packet per cycle while rsp_ready
//   does not stall it, moving to the next pending group with each packet. The
//   first packet is registered in the output register after the instruction is
//   taken. req_ready is high whenever no instruction is being split, also
//   while the final packet waits in the output register.
// Reset:
//   Synchronous, active high; the unit comes up idle with rsp_valid low.
// Stalls:
//   When rsp_ready is low the held packet stays stable and the group walk
//   pauses until the packet is taken.

module thread_mask_packet_splitter_unit #(
   parameter int THREADS = 32,
   parameter int LANES = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  tmps_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output tmps_pkg::rsp_type rsp_data
);

   tmps_pkg::ctl_cmd_type cmd;
   tmps_pkg::dp_sts_type  sts;

   // sequencing
   tmps_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   // group walk and packet formation
   tmps_datapath #(
      .THREADS (THREADS),
      .LANES   (LANES)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .sts      (sts),
      .req_data (req_data),
      .rsp_data (rsp_data)
   );

endmodule

@@ verif/thread_mask_packet_splitter_unit_test.sv @@
// self-checking testbench for the thread mask packet splitter unit
`timescale 1ns / 1ps

module thread_mask_packet_splitter_unit_test;

   localparam int THREADS = 32;
   localparam int LANES = 8;
   localparam int HALF_PERIOD = 4;
   localparam int HOLD_CYCLES = 60;
   localparam int DRAIN_LIMIT = 2000;

   // tracks the packets each accepted instruction must produce
   class lane_packet_tracker;
      tmps_pkg::rsp_type pending_packets[$];
      int      instructions_seen;
      int      packets_checked;
      int      empty_masks;
      int      multi_packet;
      int      failures;

      // split one instruction into its expected packets
      function void note_instruction(tmps_pkg::req_type item);
         int unsigned live;
         int unsigned group_count;
         int unsigned first_group;
         int unsigned last_group;
         int unsigned t;
         bit          found;
         bit          active[tmps_pkg::MAX_GROUPS];
         logic [7:0]  lanes[tmps_pkg::MAX_GROUPS];
         logic [31:0] clipped;
         tmps_pkg::rsp_type pkt;
         int          produced;
         live = (THREADS < 32) ? THREADS : 32;
         found = 1'b0;
         first_group = 0;
         last_group = 0;
         produced = 0;
         instructions_seen++;
         pkt.tag_out = item.instr_tag;

         // pass-through when one group covers every thread
         if (LANES >= THREADS) begin
            clipped = item.thread_mask;
            if (live < 32) clipped = clipped & ((32'h1 << live) - 32'h1);
            pkt.lane_mask = clipped[7:0];
            pkt.group_index = '0;
            pkt.sop_out = item.start_of_packet;
            pkt.eop_out = item.end_of_packet;
            pkt.last = 1'b1;
            pending_packets.push_back(pkt);
            return;
         end

         group_count = (live + LANES - 1) / LANES;
         if (group_count > tmps_pkg::MAX_GROUPS) group_count = tmps_pkg::MAX_GROUPS;

         // gather lane bits and activity per group
         for (int unsigned g = 0; g < tmps_pkg::MAX_GROUPS; g++) begin
            active[g] = 1'b0;
            lanes[g] = '0;
            if (g < group_count) begin
               for (int unsigned k = 0; k < LANES; k++) begin
                  t = g * LANES + k;
                  if (t < live && item.thread_mask[t]) begin
                     active[g] = 1'b1;
                     if (k < 8) lanes[g][k] = 1'b1;
                  end
               end
               if (active[g]) begin
                  if (!found) first_group = g;
                  last_group = g;
                  found = 1'b1;
               end
            end
         end

         // empty mask gives a single packet for group 0
         if (!found) begin
            empty_masks++;
            pkt.lane_mask = '0;
            pkt.group_index = '0;
            pkt.sop_out = item.start_of_packet;
            pkt.eop_out = item.end_of_packet;
            pkt.last = 1'b1;
            pending_packets.push_back(pkt);
            return;
         end

         // one packet per active group, idle groups skipped
         for (int unsigned g = first_group; g <= last_group; g++) begin
            if (active[g]) begin
               pkt.lane_mask = lanes[g];
               pkt.group_index = g[tmps_pkg::GRP_W-1:0];
               pkt.sop_out = (produced == 0) ? item.start_of_packet : 1'b0;
               pkt.eop_out = (g == last_group) ? item.end_of_packet : 1'b0;
               pkt.last = (g == last_group);
               pending_packets.push_back(pkt);
               produced++;
            end
         end
         if (produced > 1) multi_packet++;
      endfunction

      function void report_field(string field, logic [31:0] want, logic [31:0] got);
         $display("%0t: %s mismatch, expected 0x%0h actual 0x%0h", $time, field, want, got);
      endfunction

      // compare one delivered packet with the oldest expectation
      function void check_packet(tmps_pkg::rsp_type got);
         tmps_pkg::rsp_type want;
         bit      bad;
         bad = 1'b0;
         packets_checked++;
         if (pending_packets.size() == 0) begin
            $display("%0t: unexpected packet, expected none actual %p", $time, got);
            failures++;
            return;
         end
         want = pending_packets.pop_front();
         if (got.lane_mask !== want.lane_mask) begin
            report_field("lane_mask", 32'(want.lane_mask), 32'(got.lane_mask));
            bad = 1'b1;
         end
         if (got.group_index !== want.group_index) begin
            report_field("group_index", 32'(want.group_index), 32'(got.group_index));
            bad = 1'b1;
         end
         if (got.sop_out !== want.sop_out) begin
            report_field("sop_out", 32'(want.sop_out), 32'(got.sop_out));
            bad = 1'b1;
         end
         if (got.eop_out !== want.eop_out) begin
            report_field("eop_out", 32'(want.eop_out), 32'(got.eop_out));
            bad = 1'b1;
         end
         if (got.tag_out !== want.tag_out) begin
            report_field("tag_out", want.tag_out, got.tag_out);
            bad = 1'b1;
         end
         if (got.last !== want.last) begin
            report_field("last", 32'(want.last), 32'(got.last));
            bad = 1'b1;
         end
         if (bad) failures++;
      endfunction

      function int outstanding();
         return pending_packets.size();
      endfunction
   endclass

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   tmps_pkg::req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   tmps_pkg::rsp_type rsp_data;

   lane_packet_tracker tracker = new();

   // sender and receiver idling controls
   bit calm = 1'b0;
   bit hold_req = 1'b0;
   int hold_left = 0;

   thread_mask_packet_splitter_unit #(
      .THREADS(THREADS),
      .LANES(LANES)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data)
   );

   // clock generation
   always #HALF_PERIOD clock = ~clock;

   // watchdog
   initial begin
      #2_000_000;
      $display("thread_mask_packet_splitter_unit regression: fail");
      $finish;
   end

   // observe both channels at the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) tracker.note_instruction(req_data);
         if (rsp_valid && rsp_ready) tracker.check_packet(rsp_data);
      end
   end

   // receiver backpressure, with a long hold-off on request
   always @(negedge clock) begin
      if (hold_req) begin
         hold_left = HOLD_CYCLES;
         hold_req = 1'b0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (calm) begin
         rsp_ready <= 1'b1;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= 10);
      end
   end

   function automatic tmps_pkg::req_type make_instruction(logic [31:0] mask, logic sop,
                                                          logic eop, logic [31:0] tag);
      tmps_pkg::req_type item;
      item.thread_mask = mask;
      item.start_of_packet = sop;
      item.end_of_packet = eop;
      item.instr_tag = tag;
      return item;
   endfunction

   // mostly group-structured masks, some fully random or empty
   function automatic tmps_pkg::req_type random_instruction();
      logic [31:0] mask;
      int          pick;
      pick = $urandom_range(0, 9);
      if (pick < 2) begin
         mask = $urandom;
      end else if (pick == 2) begin
         mask = '0;
      end else begin
         for (int g = 0; g < tmps_pkg::MAX_GROUPS; g++) begin
            case ($urandom_range(0, 5))
               0, 1: mask[g*8 +: 8] = 8'h00;
               2: mask[g*8 +: 8] = 8'hff;
               3: mask[g*8 +: 8] = 8'h01 << $urandom_range(0, 7);
               default: mask[g*8 +: 8] = 8'($urandom);
            endcase
         end
      end
      return make_instruction(mask, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                              $urandom);
   endfunction

   // offer one transaction and hold it until accepted
   task automatic send_instruction(tmps_pkg::req_type item);
      if (!calm) begin
         while ($urandom_range(0, 99) < 10) begin
            @(negedge clock);
            req_valid <= 1'b0;
         end
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic send_random(int count);
      repeat (count) send_instruction(random_instruction());
   endtask

   // sender pause until every expected packet is back
   task automatic wait_drained();
      int waited;
      waited = 0;
      @(negedge clock);
      req_valid <= 1'b0;
      while (tracker.outstanding() != 0 && waited < DRAIN_LIMIT) begin
         @(negedge clock);
         waited++;
      end
   endtask

   initial begin
      tmps_pkg::req_type directed[$];
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // field extremes, empty mask, single and skipped groups
      directed.push_back(make_instruction(32'h0000_0000, 1'b1, 1'b1, 32'h0000_0000));
      directed.push_back(make_instruction(32'h0000_0000, 1'b0, 1'b0, 32'hffff_ffff));
      directed.push_back(make_instruction(32'hffff_ffff, 1'b1, 1'b1, 32'hffff_ffff));
      directed.push_back(make_instruction(32'hffff_ffff, 1'b0, 1'b0, 32'h0000_0000));
      directed.push_back(make_instruction(32'h0000_00ff, 1'b1, 1'b0, 32'h1234_5678));
      directed.push_back(make_instruction(32'hff00_0000, 1'b0, 1'b1, 32'h8765_4321));
      directed.push_back(make_instruction(32'h0000_0001, 1'b1, 1'b1, 32'h0000_0001));
      directed.push_back(make_instruction(32'h8000_0000, 1'b1, 1'b1, 32'h8000_0000));
      directed.push_back(make_instruction(32'h0100_0001, 1'b1, 1'b1, 32'hdead_beef));
      directed.push_back(make_instruction(32'h0001_0100, 1'b1, 1'b1, 32'hcafe_f00d));
      directed.push_back(make_instruction(32'h0000_ff00, 1'b0, 1'b1, 32'h5555_5555));
      directed.push_back(make_instruction(32'h00ff_0000, 1'b1, 1'b0, 32'haaaa_aaaa));
      directed.push_back(make_instruction(32'h8181_8181, 1'b1, 1'b1, 32'h0f0f_0f0f));
      directed.push_back(make_instruction(32'h8000_0001, 1'b1, 1'b0, 32'hf0f0_f0f0));
      directed.push_back(make_instruction(32'h0080_0100, 1'b0, 1'b1, 32'h0000_ffff));
      directed.push_back(make_instruction(32'h5555_aaaa, 1'b1, 1'b1, 32'hffff_0000));
      directed.push_back(make_instruction(32'haaaa_5555, 1'b0, 1'b0, 32'h7fff_ffff));
      foreach (directed[i]) send_instruction(directed[i]);
      wait_drained();

      // random traffic with idling on both sides
      send_random(40);

      // receiver holds off while the sender keeps offering back to back
      hold_req = 1'b1;
      calm = 1'b1;
      send_random(12);
      calm = 1'b0;
      wait_drained();

      // stretch with no idling at all
      calm = 1'b1;
      send_random(30);
      calm = 1'b0;
      send_random(11);
      wait_drained();
      repeat (10) @(negedge clock);

      $display("covered %0d instructions, %0d packets checked", tracker.instructions_seen,
               tracker.packets_checked);
      $display("%0d empty masks, %0d split into several packets", tracker.empty_masks,
               tracker.multi_packet);
      if (tracker.outstanding() != 0)
         $display("%0t: %0d expected packets never arrived", $time, tracker.outstanding());
      if (tracker.failures == 0 && tracker.outstanding() == 0) begin
         $display("thread_mask_packet_splitter_unit regression: pass");
      end else begin
         $display("thread_mask_packet_splitter_unit regression: fail");
      end
      $finish;
   end

endmodule
